FILE: hdl/mscc_pkg.sv
// ----------------------------------------------------------------------------
// mscc_pkg
// types and constants for the marching-squares cell classifier
// ----------------------------------------------------------------------------
package mscc_pkg;

	localparam int XW = 6;
	localparam int YW = 11;
	localparam int PW = 16;
	localparam int AW_APB = 3;
	localparam int DW_APB = 32;

	localparam logic [3:0] CODE_SADDLE_A = 4'd5;
	localparam logic [3:0] CODE_SADDLE_B = 4'd10;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RBORD,
		ST_BOT
	} state_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic [3:0]    code;
		logic [3:0]    sides;
		logic          saddle;
		logic          last;
	} cell_t;

	function automatic cell_t make_cell(logic [XW-1:0] x, logic [YW-1:0] y,
		logic tl, logic tr, logic br, logic bl, logic last);
		cell_t c;
		c.x      = x;
		c.y      = y;
		c.code   = {tl, tr, br, bl};
		c.sides  = {tl ^ bl, bl ^ br, tr ^ br, tl ^ tr};
		c.saddle = (c.code == CODE_SADDLE_A) || (c.code == CODE_SADDLE_B);
		c.last   = last;
		return c;
	endfunction

endpackage

FILE: hdl/marching_squares_cell_classifier.sv
// ----------------------------------------------------------------------------
// marching_squares_cell_classifier
// classifies bordered marching-squares cells from a row-order pixel stream
// ----------------------------------------------------------------------------
// an item is a line store read, then the result into the output register (waits while out_stall)
// the last pixel of a row adds the right border cell
// the last pixel of a frame adds width+1 bottom border cells
// reset clears counters and handshakes, registers go to 32 x 32; line store not cleared
// ----------------------------------------------------------------------------
module marching_squares_cell_classifier #(
	parameter int MAX_WIDTH  = 32,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mscc_pkg::AW_APB-1:0]      paddr,
	input  logic [mscc_pkg::DW_APB-1:0]      pwdata,
	output logic [mscc_pkg::DW_APB-1:0]      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [mscc_pkg::PW-1:0]          pixel_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mscc_pkg::XW-1:0]          cell_x,
	output logic [mscc_pkg::YW-1:0]          cell_y,
	output logic [3:0]                       case_code,
	output logic [3:0]                       crossed_sides,
	output logic                             saddle,
	output logic                             frame_last
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [mscc_pkg::XW-1:0] W_MAX = mscc_pkg::XW'(MAX_WIDTH);
	localparam logic [mscc_pkg::YW-1:0] H_MAX = mscc_pkg::YW'(MAX_HEIGHT);

	mscc_pkg::state_t state_q, state_nxt;

	logic [mscc_pkg::XW-1:0] width_q;
	logic [mscc_pkg::YW-1:0] height_q;
	logic [mscc_pkg::XW-1:0] col_q, icol_q, j_q, w_eff, c_acc;
	logic [mscc_pkg::YW-1:0] row_q, irow_q, h_eff, r_acc;
	logic left_q, above_left_q, cur_q, tr_q, a_q, rd_q;

	logic mem_q [MAX_WIDTH];
	logic          mem_re, mem_we;
	logic [AW-1:0] mem_raddr;

	logic           out_valid_q;
	mscc_pkg::cell_t out_q, cell_nxt;
	logic           load, can_load, cfg_wr;
	logic           tr_now, b_now;
	logic [mscc_pkg::XW-1:0] j_inc;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == mscc_pkg::REG_HEIGHT) ?
		mscc_pkg::DW_APB'(height_q) : mscc_pkg::DW_APB'(width_q);

	assign w_eff = (width_q == '0) ? mscc_pkg::XW'(1) :
		((width_q > W_MAX) ? W_MAX : width_q);
	assign h_eff = (height_q == '0) ? mscc_pkg::YW'(1) :
		((height_q > H_MAX) ? H_MAX : height_q);
	assign c_acc = (col_q >= w_eff) ? w_eff - 1'b1 : col_q;
	assign r_acc = (row_q >= h_eff) ? h_eff - 1'b1 : row_q;

	assign can_load = !out_valid_q || !out_stall;
	assign tr_now   = (irow_q != '0) && rd_q;
	assign b_now    = (j_q < w_eff) && rd_q;
	assign j_inc    = j_q + 1'b1;

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		load      = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = c_acc[AW-1:0];
		cell_nxt  = mscc_pkg::make_cell(icol_q, irow_q,
			(icol_q != '0) && above_left_q, tr_now, cur_q,
			(icol_q != '0) && left_q, 1'b0);
		case (state_q)
			mscc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					mem_re    = 1'b1;
					state_nxt = mscc_pkg::ST_READ;
				end
			end
			mscc_pkg::ST_READ: begin
				if (can_load) begin
					load   = 1'b1;
					mem_we = 1'b1;
					state_nxt = (icol_q == w_eff - 1'b1) ?
						mscc_pkg::ST_RBORD : mscc_pkg::ST_IDLE;
				end
			end
			mscc_pkg::ST_RBORD: begin
				cell_nxt = mscc_pkg::make_cell(w_eff, irow_q, tr_q, 1'b0, 1'b0,
					cur_q, 1'b0);
				mem_raddr = '0;
				if (can_load) begin
					load = 1'b1;
					if (irow_q == h_eff - 1'b1) begin
						mem_re    = 1'b1;
						state_nxt = mscc_pkg::ST_BOT;
					end else begin
						state_nxt = mscc_pkg::ST_IDLE;
					end
				end
			end
			mscc_pkg::ST_BOT: begin
				cell_nxt = mscc_pkg::make_cell(j_q, h_eff, a_q, b_now, 1'b0, 1'b0,
					j_q == w_eff);
				mem_raddr = j_inc[AW-1:0];
				if (can_load) begin
					load   = 1'b1;
					mem_re = j_inc < w_eff;
					if (j_q == w_eff) begin
						state_nxt = mscc_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = mscc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mscc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[icol_q[AW-1:0]] <= cur_q;
		end
		if (mem_re) begin
			rd_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= mscc_pkg::XW'(32);
			height_q     <= mscc_pkg::YW'(32);
			col_q        <= '0;
			row_q        <= '0;
			left_q       <= 1'b0;
			above_left_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == mscc_pkg::ST_READ && load) begin
				if (icol_q == w_eff - 1'b1) begin
					col_q        <= '0;
					row_q        <= (irow_q == h_eff - 1'b1) ? '0 : irow_q + 1'b1;
					left_q       <= 1'b0;
					above_left_q <= 1'b0;
				end else begin
					col_q        <= icol_q + 1'b1;
					row_q        <= irow_q;
					left_q       <= cur_q;
					above_left_q <= tr_now;
				end
			end
			if (cfg_wr) begin
				if (paddr[2] == mscc_pkg::REG_HEIGHT) begin
					height_q <= pwdata[mscc_pkg::YW-1:0];
				end else begin
					width_q <= pwdata[mscc_pkg::XW-1:0];
				end
				col_q        <= '0;
				row_q        <= '0;
				left_q       <= 1'b0;
				above_left_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mscc_pkg::ST_IDLE && in_valid) begin
			icol_q <= c_acc;
			irow_q <= r_acc;
			cur_q  <= (pixel_value != '0);
		end
		if (state_q == mscc_pkg::ST_READ && load) begin
			tr_q <= tr_now;
		end
		if (state_q == mscc_pkg::ST_RBORD) begin
			j_q <= '0;
			a_q <= 1'b0;
		end
		if (state_q == mscc_pkg::ST_BOT && load) begin
			j_q <= j_inc;
			a_q <= b_now;
		end
		if (load) begin
			out_q <= cell_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign cell_x        = out_q.x;
	assign cell_y        = out_q.y;
	assign case_code     = out_q.code;
	assign crossed_sides = out_q.sides;
	assign saddle        = out_q.saddle;
	assign frame_last    = out_q.last;

endmodule
